[hw/rtl/sfr_pkg.sv]
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

  localparam int ByteW = 8;
  localparam int PosW  = 9;
  localparam int CapW  = 9;
  localparam int IdxW  = 2;
  localparam int DataW = 9;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [CapW-1:0]  cap_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [DataW-1:0] data_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CHECK   = 3'd3,
    PH_GOOD    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef enum logic [IdxW-1:0] {
    REG_HEADER   = 2'd0,
    REG_CAPACITY = 2'd1,
    REG_CHECK_EN = 2'd2
  } reg_idx_t;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam byte_t HeaderReset   = '0;
  localparam cap_t  CapacityReset = 9'd256;
  localparam logic  CheckEnReset  = 1'b1;

  typedef struct packed {
    byte_t header_byte;
    cap_t  buffer_capacity;
    logic  check_enable;
  } cfg_t;

  typedef struct packed {
    logic   store_valid;
    pos_t   store_position;
    byte_t  store_byte;
    phase_t frame_state;
  } result_t;

endpackage

[hw/rtl/sfr_config_regs.sv]
// Configuration register file for the frame receiver.
module sfr_config_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sfr_pkg::idx_t  wr_index,
  input  sfr_pkg::data_t wr_data,
  output sfr_pkg::cfg_t  cfg
);
  import sfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte     <= HeaderReset;
      cfg.buffer_capacity <= CapacityReset;
      cfg.check_enable    <= CheckEnReset;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_HEADER:   cfg.header_byte     <= wr_data[ByteW-1:0];
        REG_CAPACITY: cfg.buffer_capacity <= wr_data[CapW-1:0];
        REG_CHECK_EN: cfg.check_enable    <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/sfr_parser.sv]
// Frame parser state machine: phase, length, count and running sum.
module sfr_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            cmd,
  input  sfr_pkg::byte_t   rx_byte,
  input  sfr_pkg::cfg_t    cfg,
  output sfr_pkg::result_t result
);
  import sfr_pkg::*;

  phase_t phase, phase_next;
  byte_t  payload_length, payload_length_next;
  byte_t  payload_received, payload_received_next;
  byte_t  running_sum, running_sum_next;

  byte_t  count_inc;
  byte_t  sum_inc;
  logic   len_ok;
  logic   sum_ok;

  assign count_inc = payload_received + 8'd1;
  assign sum_inc   = running_sum + rx_byte;
  assign len_ok    = (rx_byte != '0) && ({1'b0, rx_byte} < cfg.buffer_capacity);
  assign sum_ok    = (sum_inc == '0);

  // Next state
  always_comb begin
    phase_next            = phase;
    payload_length_next   = payload_length;
    payload_received_next = payload_received;
    running_sum_next      = running_sum;
    if (cmd == CMD_RESTART) begin
      phase_next            = PH_HUNT;
      payload_length_next   = '0;
      payload_received_next = '0;
      running_sum_next      = '0;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.header_byte) begin
            running_sum_next = rx_byte;
            phase_next       = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          payload_received_next = '0;
          if (len_ok) begin
            running_sum_next    = sum_inc;
            payload_length_next = rx_byte;
            phase_next          = PH_PAYLOAD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          running_sum_next      = sum_inc;
          payload_received_next = count_inc;
          if (count_inc >= payload_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (!cfg.check_enable || sum_ok) begin
            phase_next = PH_GOOD;
          end else begin
            payload_received_next = '0;
            phase_next            = PH_ERROR;
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs
  always_comb begin
    result.store_valid    = 1'b0;
    result.store_position = '0;
    result.store_byte     = '0;
    result.frame_state    = phase_next;
    if (cmd == CMD_BYTE) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.header_byte) begin
            result.store_valid = 1'b1;
          end
        end
        PH_LENGTH: begin
          if (len_ok) begin
            result.store_valid    = 1'b1;
            result.store_position = 9'd1;
          end
        end
        PH_PAYLOAD: begin
          result.store_valid    = 1'b1;
          result.store_position = {1'b0, payload_received} + 9'd2;
        end
        default: ;
      endcase
      if (result.store_valid) begin
        result.store_byte = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      payload_length   <= '0;
      payload_received <= '0;
      running_sum      <= '0;
    end else if (step) begin
      phase            <= phase_next;
      payload_length   <= payload_length_next;
      payload_received <= payload_received_next;
      running_sum      <= running_sum_next;
    end
  end

endmodule

[hw/rtl/serial_frame_receiver_checksum.sv]
// Serial frame receiver top level: input register, parser, result register.
// Parses header, length, payload, checksum frames one received byte per
// transfer and returns one result per byte: whether and where the byte is
// stored in the frame buffer, and the parser phase after it. Sustained rate is
// one byte per clock while out_ready stays high; a result is held first in the
// input register and then in the result register, with the parser state
// updated as the byte moves between them.
// Configuration writes are taken at any time and apply to the next byte.
module serial_frame_receiver_checksum (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  input  sfr_pkg::byte_t   rx_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            store_valid,
  output sfr_pkg::pos_t    store_position,
  output sfr_pkg::byte_t   store_byte,
  output logic [2:0]      frame_state,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  sfr_pkg::idx_t    cfg_index,
  input  sfr_pkg::data_t   cfg_data
);
  import sfr_pkg::*;

  logic    hold_valid;
  logic    hold_cmd;
  byte_t   hold_byte;
  logic    step;
  cfg_t    cfg;
  result_t result;
  result_t out_q;

  assign step      = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cmd  <= cmd;
      hold_byte <= rx_byte;
    end
  end

  sfr_config_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .cmd     (hold_cmd),
    .rx_byte (hold_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign store_valid    = out_q.store_valid;
  assign store_position = out_q.store_position;
  assign store_byte     = out_q.store_byte;
  assign frame_state    = out_q.frame_state;

endmodule

[hw/rtl/sfr_checker.sv]
// Port-level checker for the serial frame receiver, with its bind.
module sfr_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input logic           store_valid,
  input sfr_pkg::pos_t   store_position,
  input sfr_pkg::byte_t  store_byte,
  input logic [2:0]     frame_state
);
  import sfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(store_valid)
      && $stable(store_position) && $stable(store_byte) && $stable(frame_state))
    else $error("result changed while stalled");

  a_no_store_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_valid |-> store_position == '0 && store_byte == '0)
    else $error("unstored result carries position or byte");

  a_store_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_valid |-> frame_state == PH_LENGTH
      || frame_state == PH_PAYLOAD || frame_state == PH_CHECK)
    else $error("store reported in a phase that cannot store");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_valid && store_position == '0 |-> frame_state == PH_LENGTH)
    else $error("header store not followed by length phase");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind serial_frame_receiver_checksum sfr_checker u_sfr_checker (.*);
